// ----- src/spid_pkg.sv -----
// Shared constants, types and register reset values of the servo PID pulse controller.
package spid_pkg;

   // Fraction bits of the fixed-point gains (Q11.20 by default).
   localparam int GAIN_FRAC_BITS = 20;

   localparam int GAIN_W  = 32;
   localparam int POS_W   = 16;
   localparam int ERR_W   = POS_W + 1;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int SUM_W   = 32;
   localparam int ACC_W   = 64;
   localparam int PULSE_W = 12;
   localparam int LIMIT_W = 15;
   localparam int OFFS_W  = 16;
   localparam int WIDE_W  = PULSE_W + 6;
   localparam int INDEX_W = 3;
   localparam int DATA_W  = 32;

   // Rounding bias that turns an arithmetic shift into truncation toward zero.
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
      ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic [LIMIT_W-1:0]        limit_type;
   typedef logic signed [OFFS_W-1:0]  offs_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic [DATA_W-1:0]         data_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_GAIN_PROP    = 3'd0,
      REG_GAIN_INTEG   = 3'd1,
      REG_GAIN_DERIV   = 3'd2,
      REG_CENTRE_PULSE = 3'd3,
      REG_PULSE_MIN    = 3'd4,
      REG_PULSE_MAX    = 3'd5,
      REG_OFFSET_LIMIT = 3'd6
   } reg_index_type;

   typedef struct packed {
      gain_type  gain_prop;
      gain_type  gain_integ;
      gain_type  gain_deriv;
      pulse_type centre_pulse;
      pulse_type pulse_min;
      pulse_type pulse_max;
      limit_type offset_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_prop:    -32'sd417333,
      gain_integ:   -32'sd10,
      gain_deriv:   -32'sd262134,
      centre_pulse: 12'd1500,
      pulse_min:    12'd500,
      pulse_max:    12'd2500,
      offset_limit: 15'd1000
   };

endpackage

// ----- src/spid_if.sv -----
// Handshake channel interfaces: position beats in, pulse beats out, register writes.
interface spid_req_if;
   import spid_pkg::*;
   logic    valid;
   logic    ready;
   pos_type measured;
   pos_type target;
   modport source (output valid, output measured, output target, input ready);
   modport sink   (input valid, input measured, input target, output ready);
endinterface

interface spid_rsp_if;
   import spid_pkg::*;
   logic      valid;
   logic      ready;
   pulse_type pulse_us;
   offs_type  drive_offset;
   modport source (output valid, output pulse_us, output drive_offset, input ready);
   modport sink   (input valid, input pulse_us, input drive_offset, output ready);
endinterface

interface spid_csr_if;
   import spid_pkg::*;
   logic      valid;
   logic      ready;
   index_type index;
   data_type  wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- src/spid_csr.sv -----
// Configuration register file of the servo PID pulse controller.
module spid_csr (
   input  logic              clock,
   input  logic              reset,
   spid_csr_if.sink          csr_ch,
   output spid_pkg::cfg_type cfg
);
   import spid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_GAIN_PROP:    cfg_in.gain_prop    = gain_type'(csr_ch.wdata);
            REG_GAIN_INTEG:   cfg_in.gain_integ   = gain_type'(csr_ch.wdata);
            REG_GAIN_DERIV:   cfg_in.gain_deriv   = gain_type'(csr_ch.wdata);
            REG_CENTRE_PULSE: cfg_in.centre_pulse = csr_ch.wdata[PULSE_W-1:0];
            REG_PULSE_MIN:    cfg_in.pulse_min    = csr_ch.wdata[PULSE_W-1:0];
            REG_PULSE_MAX:    cfg_in.pulse_max    = csr_ch.wdata[PULSE_W-1:0];
            REG_OFFSET_LIMIT: cfg_in.offset_limit = csr_ch.wdata[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/servo_pid_pulse_controller.sv -----
// Top level of the servo PID pulse controller: four-stage PID and pulse-mapping pipeline.
// A result beat passes stages 1 to 4 in order and is offered by the stage 4 register.
// Throughput: one beat per cycle while rsp_ch.ready is high; each stage holds its contents
// only while the stage after it is full and blocked, so req_ch.ready falls only when all four
// stages are full.
// Reset (synchronous, active high) empties the pipeline, clears the error integral and
// the previous error, and loads the register reset values.
module servo_pid_pulse_controller (
   input  logic       clock,
   input  logic       reset,
   spid_req_if.sink   req_ch,
   spid_rsp_if.source rsp_ch,
   spid_csr_if.sink   csr_ch
);
   import spid_pkg::*;

   cfg_type cfg;

   spid_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Per-stage load enables. A stage may load when it is empty or when the
   // stage after it is loading too, so bubbles are squeezed out.
   logic load1, load2, load3, load4;
   logic accept;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;

   assign load4  = !s4_valid_ff || rsp_ch.ready;
   assign load3  = !s3_valid_ff || load4;
   assign load2  = !s2_valid_ff || load3;
   assign load1  = !s1_valid_ff || load2;
   assign accept = req_ch.valid && req_ch.ready;

   assign req_ch.ready = load1;

   // ------------------------------------------------------------------
   // Stage 1: error, saturating integral and derivative difference.
   // The loop-carried state is updated in the accept cycle, so the next
   // beat can follow straight away.
   // ------------------------------------------------------------------
   sum_type error_sum_ff, error_sum_in;
   err_type prev_err_ff, prev_err_in;

   err_type                err_in;
   logic signed [SUM_W:0]  sum_wide;
   diff_type               diff_in;

   err_type  s1_err_ff;
   sum_type  s1_sum_ff;
   diff_type s1_diff_ff;

   assign err_in   = err_type'(req_ch.target) - err_type'(req_ch.measured);
   assign sum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err_in);
   assign diff_in  = diff_type'(err_in) - diff_type'(prev_err_ff);

   always_comb begin
      error_sum_in = error_sum_ff;
      prev_err_in  = prev_err_ff;
      if (accept) begin
         // Clamp the integral to the 32-bit signed range.
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            error_sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
         end else begin
            error_sum_in = sum_wide[SUM_W-1:0];
         end
         prev_err_in = err_in;
      end
   end

   assign s1_valid_in = load1 ? accept : s1_valid_ff;

   // ------------------------------------------------------------------
   // Stage 2: the three gain products of the 32-bit gains with the 17-bit error, 32-bit integral and 18-bit difference.
   // ------------------------------------------------------------------
   logic signed [GAIN_W+ERR_W-1:0]  prod_p_in, s2_prod_p_ff;
   logic signed [GAIN_W+SUM_W-1:0]  prod_i_in, s2_prod_i_ff;
   logic signed [GAIN_W+DIFF_W-1:0] prod_d_in, s2_prod_d_ff;

   assign prod_p_in = (GAIN_W+ERR_W)'(cfg.gain_prop) * (GAIN_W+ERR_W)'(s1_err_ff);
   assign prod_i_in = (GAIN_W+SUM_W)'(cfg.gain_integ) * (GAIN_W+SUM_W)'(s1_sum_ff);
   assign prod_d_in = (GAIN_W+DIFF_W)'(cfg.gain_deriv) * (GAIN_W+DIFF_W)'(s1_diff_ff);

   assign s2_valid_in = load2 ? s1_valid_ff : s2_valid_ff;

   // ------------------------------------------------------------------
   // Stage 3: exact sum of the products. The magnitude stays below 2^63.
   // ------------------------------------------------------------------
   acc_type acc_in, s3_acc_ff;

   assign acc_in = ACC_W'(s2_prod_p_ff) + ACC_W'(s2_prod_i_ff) + ACC_W'(s2_prod_d_ff);

   assign s3_valid_in = load3 ? s2_valid_ff : s3_valid_ff;

   // ------------------------------------------------------------------
   // Stage 4: drop the fraction toward zero, clamp to the offset limit,
   // map around the centre pulse and clamp to the pulse range. The
   // maximum clamp comes first, so an inverted range yields the minimum.
   // ------------------------------------------------------------------
   acc_type                    acc_biased;
   acc_type                    quot;
   acc_type                    limit_pos;
   acc_type                    limit_neg;
   offs_type                   offs_in;
   logic signed [WIDE_W-1:0]   pulse_raw;
   logic signed [WIDE_W-1:0]   pulse_hi;
   logic signed [WIDE_W-1:0]   pulse_lo;
   logic signed [WIDE_W-1:0]   pulse_clamped;
   pulse_type                  pulse_in;

   pulse_type s4_pulse_ff;
   offs_type  s4_offs_ff;

   assign acc_biased = s3_acc_ff + (s3_acc_ff[ACC_W-1] ? TRUNC_BIAS : '0);
   assign quot       = acc_biased >>> GAIN_FRAC_BITS;
   assign limit_pos  = ACC_W'({1'b0, cfg.offset_limit});
   assign limit_neg  = -limit_pos;

   always_comb begin
      if (quot > limit_pos) begin
         offs_in = OFFS_W'(limit_pos);
      end else if (quot < limit_neg) begin
         offs_in = OFFS_W'(limit_neg);
      end else begin
         offs_in = OFFS_W'(quot);
      end
   end

   assign pulse_raw = WIDE_W'({1'b0, cfg.centre_pulse}) - WIDE_W'(offs_in);
   assign pulse_hi  = WIDE_W'({1'b0, cfg.pulse_max});
   assign pulse_lo  = WIDE_W'({1'b0, cfg.pulse_min});

   always_comb begin
      pulse_clamped = pulse_raw;
      if (pulse_clamped > pulse_hi) begin
         pulse_clamped = pulse_hi;
      end
      if (pulse_clamped < pulse_lo) begin
         pulse_clamped = pulse_lo;
      end
      pulse_in = pulse_clamped[PULSE_W-1:0];
   end

   assign s4_valid_in = load4 ? s3_valid_ff : s4_valid_ff;

   assign rsp_ch.valid        = s4_valid_ff;
   assign rsp_ch.pulse_us     = s4_pulse_ff;
   assign rsp_ch.drive_offset = s4_offs_ff;

   // ------------------------------------------------------------------
   // Registers. Only the valid bits and the loop state are reset.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         error_sum_ff <= error_sum_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_err_ff  <= err_in;
         s1_sum_ff  <= error_sum_in;
         s1_diff_ff <= diff_in;
      end
      if (load2) begin
         s2_prod_p_ff <= prod_p_in;
         s2_prod_i_ff <= prod_i_in;
         s2_prod_d_ff <= prod_d_in;
      end
      if (load3) begin
         s3_acc_ff <= acc_in;
      end
      if (load4) begin
         s4_pulse_ff <= pulse_in;
         s4_offs_ff  <= offs_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // An accepted beat always lands in stage 1.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   // The input side only stalls when every stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff))
      else $error("input stalled with a free pipeline stage");

   // The offered drive offset never exceeds the configured limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         (rsp_ch.drive_offset <= $signed(OFFS_W'({1'b0, cfg.offset_limit})) &&
          rsp_ch.drive_offset >= -$signed(OFFS_W'({1'b0, cfg.offset_limit}))))
      else $error("drive offset outside the offset limit");

   // With an ordered range, the offered pulse lies inside it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && cfg.pulse_min <= cfg.pulse_max) |->
         (rsp_ch.pulse_us >= cfg.pulse_min && rsp_ch.pulse_us <= cfg.pulse_max))
      else $error("pulse width outside the permitted range");

endmodule

// ----- tb/servo_pid_pulse_controller_tb.sv -----
// Self-checking testbench of the servo PID pulse controller: predictor, scoreboard and drivers.
module servo_pid_pulse_controller_tb;
   import spid_pkg::*;

   // A result beat has to pass every pipeline stage before it is offered, so a short
   // settle period after the last result is enough to catch any stray beat the block
   // might still emit.
   localparam int LATENCY_CYCLES   = 4;
   localparam int SETTLE_CYCLES    = 2 * LATENCY_CYCLES;
   localparam int RESET_CYCLES     = 6;
   // The slowest correct run, with the longest gaps and stalls on every beat, needs well
   // under fifty thousand time units; the limit allows several times that.
   localparam int TIMEOUT_UNITS    = 400_000;
   localparam int DRAIN_LIMIT      = 10_000;
   localparam int HOLD_CYCLES      = 60;
   localparam int RANDOM_PHASES    = 10;
   localparam int PHASE_ITEMS      = 65;
   localparam int PRESSURE_PHASE   = 5;
   localparam int PRESSURE_ITEMS   = 30;
   localparam longint SUM_MAX      = 64'sd2147483647;
   localparam longint SUM_MIN      = -64'sd2147483648;
   // Register index that decodes to nothing; writes to it must leave every register alone.
   localparam index_type UNUSED_INDEX = 3'd7;

   typedef struct {
      pulse_type pulse_us;
      offs_type  drive_offset;
   } pulse_beat_t;

   // The scoreboard mirrors the register file and the integrator state of the block, turns
   // every accepted position beat into the pulse beat it must cause, and compares the
   // result beats in order against those expectations.
   class pulse_scoreboard;
      cfg_type     regs = CFG_RESET;
      sum_type     error_sum = '0;
      err_type     previous_error = '0;
      pulse_beat_t pulse_queue[$];
      int unsigned mismatches = 0;

      task report_mismatch(input string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      function void apply_write(input index_type idx, input data_type data);
         case (idx)
            REG_GAIN_PROP:    regs.gain_prop    = gain_type'(data);
            REG_GAIN_INTEG:   regs.gain_integ   = gain_type'(data);
            REG_GAIN_DERIV:   regs.gain_deriv   = gain_type'(data);
            REG_CENTRE_PULSE: regs.centre_pulse = pulse_type'(data);
            REG_PULSE_MIN:    regs.pulse_min    = pulse_type'(data);
            REG_PULSE_MAX:    regs.pulse_max    = pulse_type'(data);
            REG_OFFSET_LIMIT: regs.offset_limit = limit_type'(data);
            default: ;
         endcase
      endfunction

      // Positional PID with a saturating integral, exact 64-bit sum, truncation toward
      // zero, offset clamp and finally the pulse clamp (maximum first, minimum second).
      function void note_position(input pos_type measured, input pos_type target);
         longint      err;
         longint      integ;
         longint      acc;
         longint      offs;
         longint      limit;
         longint      pulse;
         pulse_beat_t beat;
         err   = longint'(target) - longint'(measured);
         integ = longint'(error_sum) + err;
         if (integ > SUM_MAX) integ = SUM_MAX;
         if (integ < SUM_MIN) integ = SUM_MIN;
         error_sum = sum_type'(integ);
         acc = longint'($signed(regs.gain_prop)) * err
             + longint'($signed(regs.gain_integ)) * integ
             + longint'($signed(regs.gain_deriv)) * (err - longint'(previous_error));
         previous_error = err_type'(err);
         offs  = acc / (longint'(1) << GAIN_FRAC_BITS);
         limit = longint'(regs.offset_limit);
         if (offs > limit) offs = limit;
         else if (offs < -limit) offs = -limit;
         pulse = longint'(regs.centre_pulse) - offs;
         if (pulse > longint'(regs.pulse_max)) pulse = longint'(regs.pulse_max);
         if (pulse < longint'(regs.pulse_min)) pulse = longint'(regs.pulse_min);
         beat.pulse_us     = pulse_type'(pulse);
         beat.drive_offset = offs_type'(offs);
         pulse_queue.push_back(beat);
      endfunction

      task check_pulse(input pulse_type pulse_us, input offs_type drive_offset);
         pulse_beat_t beat;
         if (pulse_queue.size() == 0) begin
            report_mismatch($sformatf("result beat pulse_us=%0d drive_offset=%0d unexpected",
                                      pulse_us, drive_offset));
         end else begin
            beat = pulse_queue.pop_front();
            if (pulse_us !== beat.pulse_us) begin
               report_mismatch($sformatf("pulse_us %0d, predicted %0d",
                                         pulse_us, beat.pulse_us));
            end
            if (drive_offset !== beat.drive_offset) begin
               report_mismatch($sformatf("drive_offset %0d, predicted %0d",
                                         drive_offset, beat.drive_offset));
            end
         end
      endtask

      function int pending();
         return pulse_queue.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   spid_req_if req_bus ();
   spid_rsp_if rsp_bus ();
   spid_csr_if csr_bus ();

   pulse_scoreboard board = new();

   // Shared switches between the stimulus and the result sink. When idling is off both
   // sides run flat out; a hold request makes the sink keep ready low for a long stretch.
   bit idling_on    = 1'b1;
   bit hold_request = 1'b0;

   servo_pid_pulse_controller i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // All inputs of the block hold known values from the very start of the run.
   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.measured <= '0;
      req_bus.target <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= '0;
      csr_bus.wdata  <= '0;
   end

   // Monitor: every beat that crosses a handshake is sampled at the clock edge, before any
   // of the nonblocking updates of that edge land. Register writes happen only while the
   // block is empty, and no result can share an edge with the position beat causing it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            board.apply_write(csr_bus.index, csr_bus.wdata);
         end
         if (req_bus.valid && req_bus.ready) begin
            board.note_position(req_bus.measured, req_bus.target);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            board.check_pulse(rsp_bus.pulse_us, rsp_bus.drive_offset);
         end
      end
   end

   // Result sink. Before each beat it draws a random stall if idling is on; on a hold request
   // it keeps ready low for a long stretch, counted here, so the pipeline fills and the
   // block has to push back on its position input.
   initial begin : result_sink
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = idling_on ? $urandom_range(10, 0) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // One register write; the caller makes sure the block is empty.
   task automatic write_register(input index_type idx, input data_type data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Offers one position beat after a drawn gap. With no gap, valid simply stays high from
   // the previous beat and only the payload changes, so back-to-back beats are possible.
   task automatic send_position(input pos_type measured, input pos_type target);
      int unsigned gap;
      gap = idling_on ? $urandom_range(10, 0) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.measured <= measured;
      req_bus.target   <= target;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Withdraws the position channel and waits until every predicted pulse beat has been seen,
   // or the limit runs out; the first edge is always waited out to book the last accepted beat.
   task automatic await_results(input int limit);
      int waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (board.pending() != 0 && waited < limit);
   endtask

   // Gains are either an extreme, zero, fully random, or within one unit of the binary point
   // so that a fair share of results falls inside the offset clamp.
   function automatic data_type draw_gain();
      case ($urandom_range(5, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom();
         3: return '0;
         default: return data_type'($urandom_range(32'h0020_0000, 0)) - 32'h0010_0000;
      endcase
   endfunction

   // Narrow registers get an extreme, a small value or a random one, and sometimes junk in
   // the bits above the register so that the width truncation is exercised.
   function automatic data_type draw_narrow(input int unsigned width);
      data_type mask;
      data_type value;
      mask = (data_type'(1) << width) - 1;
      case ($urandom_range(4, 0))
         0: value = '0;
         1: value = mask;
         2: value = data_type'($urandom_range(2047, 0)) & mask;
         default: value = $urandom() & mask;
      endcase
      if ($urandom_range(1, 0) == 1) value |= $urandom() & ~mask;
      return value;
   endfunction

   task automatic scramble_registers();
      data_type low_pulse;
      data_type high_pulse;
      data_type swap;
      low_pulse  = draw_narrow(PULSE_W);
      high_pulse = draw_narrow(PULSE_W);
      // Keep the pulse range the right way round most of the time; the inverted case
      // still turns up now and then.
      if (pulse_type'(low_pulse) > pulse_type'(high_pulse) && $urandom_range(3, 0) != 0) begin
         swap       = low_pulse;
         low_pulse  = high_pulse;
         high_pulse = swap;
      end
      write_register(REG_GAIN_PROP, draw_gain());
      write_register(REG_GAIN_INTEG, draw_gain());
      write_register(REG_GAIN_DERIV, draw_gain());
      write_register(REG_CENTRE_PULSE, draw_narrow(PULSE_W));
      write_register(REG_PULSE_MIN, low_pulse);
      write_register(REG_PULSE_MAX, high_pulse);
      write_register(REG_OFFSET_LIMIT, draw_narrow(LIMIT_W));
      if ($urandom_range(3, 0) == 0) write_register(UNUSED_INDEX, $urandom());
   endtask

   // Most beats track the target closely, as a servo loop does, so the PID terms stay
   // inside the clamps; the rest are arbitrary positions.
   task automatic send_random_position();
      pos_type measured;
      pos_type target;
      measured = pos_type'($urandom());
      if ($urandom_range(9, 0) < 6) begin
         target = pos_type'(measured + $urandom_range(512, 0) - 256);
      end else begin
         target = pos_type'($urandom());
      end
      send_position(measured, target);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset register values: field extremes and the largest
      // positive and negative errors, which also give the widest derivative swings.
      send_position(16'sd0, 16'sd0);
      send_position(-16'sd32768, 16'sd32767);
      send_position(16'sd32767, -16'sd32768);
      send_position(16'sd32767, 16'sd32767);
      send_position(-16'sd32768, -16'sd32768);
      send_position(16'sd0, 16'sd32767);
      send_position(16'sd0, -16'sd32768);
      send_position(-16'sd1, 16'sd1);
      await_results(DRAIN_LIMIT);

      // Zero offset limit: the drive offset must vanish and the pulse sit at the centre,
      // first at the top of the range and then at the bottom.
      write_register(REG_OFFSET_LIMIT, '0);
      write_register(REG_PULSE_MIN, '0);
      write_register(REG_PULSE_MAX, 32'h0000_0FFF);
      write_register(REG_CENTRE_PULSE, 32'h0000_0FFF);
      send_position(-16'sd32768, 16'sd32767);
      send_position(16'sd100, -16'sd100);
      await_results(DRAIN_LIMIT);
      write_register(REG_CENTRE_PULSE, '0);
      send_position(16'sd32767, -16'sd32768);
      await_results(DRAIN_LIMIT);

      // Extreme gains with the widest offset limit drive the clamp to its ends, and an
      // inverted pulse range must leave the pulse at the minimum.
      write_register(REG_GAIN_PROP, 32'h7FFF_FFFF);
      write_register(REG_GAIN_INTEG, 32'h8000_0000);
      write_register(REG_GAIN_DERIV, 32'h8000_0000);
      write_register(REG_OFFSET_LIMIT, 32'h0000_7FFF);
      write_register(REG_CENTRE_PULSE, 32'h0000_0800);
      write_register(REG_PULSE_MIN, 32'h0000_0BB8);
      write_register(REG_PULSE_MAX, 32'h0000_03E8);
      send_position(-16'sd32768, 16'sd32767);
      send_position(16'sd32767, -16'sd32768);
      send_position(16'sd5, 16'sd3);
      send_position(16'sd0, 16'sd0);
      await_results(DRAIN_LIMIT);

      // A write to the undecoded index must change nothing.
      write_register(UNUSED_INDEX, 32'hFFFF_FFFF);
      send_position(16'sd1234, -16'sd4321);
      send_position(-16'sd7, 16'sd7);
      await_results(DRAIN_LIMIT);

      // Random phases, each with fresh register values. Every fourth phase runs without
      // idling on either side; one phase holds the sink off while beats keep coming.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         scramble_registers();
         idling_on = (phase % 4) != 3;
         if (phase == PRESSURE_PHASE) begin
            idling_on    = 1'b0;
            hold_request = 1'b1;
            for (n = 0; n < PRESSURE_ITEMS; n++) send_random_position();
            idling_on = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) send_random_position();
         await_results(DRAIN_LIMIT);
      end

      // A last phase under random registers and idling, on top of the accumulated integral.
      idling_on = 1'b1;
      scramble_registers();
      for (n = 0; n < PHASE_ITEMS; n++) send_random_position();
      await_results(DRAIN_LIMIT);

      // Let any stray beat show itself before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.report_mismatch($sformatf("%0d predicted result beats never arrived",
                                         board.pending()));
      end
      if (board.mismatches == 0) begin
         $display("servo_pid_pulse_controller verification clean");
      end else begin
         $display("servo_pid_pulse_controller verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_UNITS);
      $display("servo_pid_pulse_controller verification failed");
      $finish;
   end

endmodule
